FILE: rtl/core/sef_pkg.sv
// ----------------------------------------------------------------------------
// Stereo envelope follower package
// Shared widths, register indexes and types for the envelope follower.
// ----------------------------------------------------------------------------
package sef_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 15;

  localparam int GAIN_W     = COEF_FRAC_BITS;
  localparam int FB_W       = COEF_FRAC_BITS + 1;
  localparam int PROD_W     = SAMPLE_BITS + COEF_FRAC_BITS + 1;
  localparam int ACC_W      = PROD_W + 1;
  localparam int QUOT_W     = ACC_W - COEF_FRAC_BITS;
  localparam int TDATA_W    = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = FB_W;

  localparam logic [CFG_ADDR_W-1:0] REG_ATTACK_GAIN      = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ATTACK_FEEDBACK  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RELEASE_GAIN     = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RELEASE_FEEDBACK = 2'd3;

  typedef struct packed {
    logic [GAIN_W-1:0] attack_gain;
    logic [FB_W-1:0]   attack_feedback;
    logic [GAIN_W-1:0] release_gain;
    logic [FB_W-1:0]   release_feedback;
  } coef_t;

  typedef struct packed {
    logic load;
    logic advance;
  } pipe_ctrl_t;

endpackage

FILE: rtl/core/sef_lane.sv
// ----------------------------------------------------------------------------
// Envelope follower lane
// One channel: input products in the first stage, then the feedback loop.
// ----------------------------------------------------------------------------
module sef_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sef_pkg::coef_t                      coef,
  input  sef_pkg::pipe_ctrl_t                 ctrl,
  input  logic signed [sef_pkg::SAMPLE_BITS-1:0] x_in,
  output logic signed [sef_pkg::SAMPLE_BITS-1:0] env
);
  import sef_pkg::*;

  localparam logic signed [QUOT_W-1:0] SAT_HI =
    QUOT_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [QUOT_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);

  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [PROD_W-1:0]      att_gx_r;
  logic signed [PROD_W-1:0]      rel_gx_r;
  logic signed [SAMPLE_BITS-1:0] prev_r;
  logic signed [SAMPLE_BITS-1:0] prev_nxt;

  logic                          rising;
  logic signed [FB_W-1:0]        fb_sel;
  logic signed [PROD_W-1:0]      gx_sel;
  logic signed [PROD_W-1:0]      fb_prod;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       acc_biased;
  logic signed [QUOT_W-1:0]      quot;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x_r      <= x_in;
      att_gx_r <= $signed({1'b0, coef.attack_gain}) * x_in;
      rel_gx_r <= $signed({1'b0, coef.release_gain}) * x_in;
    end
  end

  always_comb begin
    rising     = x_r > prev_r;
    fb_sel     = rising ? $signed(coef.attack_feedback) : $signed(coef.release_feedback);
    gx_sel     = rising ? att_gx_r : rel_gx_r;
    fb_prod    = fb_sel * prev_r;
    acc        = ACC_W'(gx_sel) + ACC_W'(fb_prod);
    acc_biased = acc + (acc[ACC_W-1] ? $signed(ROUND_BIAS) : $signed(ACC_W'(0)));
    quot       = QUOT_W'(acc_biased >>> COEF_FRAC_BITS);
    if (quot > SAT_HI) begin
      prev_nxt = SAT_HI[SAMPLE_BITS-1:0];
    end else if (quot < SAT_LO) begin
      prev_nxt = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      prev_nxt = quot[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (ctrl.advance) begin
      prev_r <= prev_nxt;
    end
  end

  assign env = prev_r;

endmodule

FILE: rtl/core/sef_ctrl.sv
// ----------------------------------------------------------------------------
// Envelope follower pipeline control
// Valid tracking for the product stage and the output stage.
// ----------------------------------------------------------------------------
module sef_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic                s1_valid,
  output sef_pkg::pipe_ctrl_t ctrl
);
  import sef_pkg::*;

  logic s1_valid_r;
  logic s1_valid_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic out_free;

  always_comb begin
    out_free     = !out_valid_r || out_tready;
    ctrl.advance = s1_valid_r && out_free;
    in_tready    = !s1_valid_r || out_free;
    ctrl.load    = in_tvalid && in_tready;

    if (ctrl.load) begin
      s1_valid_nxt = 1'b1;
    end else if (ctrl.advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (ctrl.advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign s1_valid   = s1_valid_r;

endmodule

FILE: rtl/core/stereo_envelope_follower_top.sv
// ----------------------------------------------------------------------------
// Stereo envelope follower
// Attack/release one-pole envelope follower for a stereo sample stream.
// ----------------------------------------------------------------------------
// One input beat carries a left and a right sample; one output beat carries
// the two envelope values that follow from it. Both channels share the four
// coefficient registers, written through the cfg port; write them only while
// the block is idle, which the block itself does not enforce.
// Both gains are applied as the sample enters the product stage. The sample
// then waits there while the feedback multiply, add and saturation form the
// loop from one envelope value to the next. The result is registered in the
// envelope registers, together with out_tvalid, as the beat leaves the
// product stage. One beat per cycle is accepted for as long as the output
// side takes them.
// Reset clears the coefficients, both envelopes and all pending beats.
// When the receiver stalls, the output beat is held and the product stage
// keeps at most one further beat; input is then refused until space frees.
// ----------------------------------------------------------------------------
module stereo_envelope_follower_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // left_in, right_in
  input  logic [sef_pkg::TDATA_W-1:0]         in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // left_env, right_env
  output logic [sef_pkg::TDATA_W-1:0]         out_tdata,
  input  logic                                cfg_wr_en,
  input  logic [sef_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [sef_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import sef_pkg::*;

  coef_t      coef_r;
  coef_t      coef_nxt;
  pipe_ctrl_t ctrl;
  logic       s1_valid;

  logic signed [SAMPLE_BITS-1:0] left_env;
  logic signed [SAMPLE_BITS-1:0] right_env;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_ATTACK_GAIN:      coef_nxt.attack_gain      = cfg_wdata[GAIN_W-1:0];
        REG_ATTACK_FEEDBACK:  coef_nxt.attack_feedback  = cfg_wdata[FB_W-1:0];
        REG_RELEASE_GAIN:     coef_nxt.release_gain     = cfg_wdata[GAIN_W-1:0];
        REG_RELEASE_FEEDBACK: coef_nxt.release_feedback = cfg_wdata[FB_W-1:0];
        default:              coef_nxt = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  sef_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .s1_valid   (s1_valid),
    .ctrl       (ctrl)
  );

  sef_lane u_lane_left (
    .clk   (clk),
    .rst_n (rst_n),
    .coef  (coef_r),
    .ctrl  (ctrl),
    .x_in  ($signed(in_tdata[SAMPLE_BITS-1:0])),
    .env   (left_env)
  );

  sef_lane u_lane_right (
    .clk   (clk),
    .rst_n (rst_n),
    .coef  (coef_r),
    .ctrl  (ctrl),
    .x_in  ($signed(in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
    .env   (right_env)
  );

  assign out_tdata = TDATA_W'({right_env, left_env});

  a_accept_fills_stage : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> s1_valid)
    else $error("Accepted beat did not reach the product stage.");

  a_stage_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !ctrl.advance) |=> s1_valid)
    else $error("Beat in the product stage was lost.");

  a_advance_fills_output : assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.advance |=> out_tvalid)
    else $error("Advanced beat did not reach the output.");

  a_envelope_held : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(left_env) && $stable(right_env)))
    else $error("Envelope changed while the output was stalled.");

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Stereo envelope follower testbench
// Drives stereo sample beats through the envelope follower under several
// coefficient settings, random idling on both sides, a long output stall and
// a drained pause. A scoreboard predicts both envelopes for every accepted
// beat and checks each output beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import sef_pkg::*;

  localparam int LIMIT_CYCLES = 200000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [TDATA_W-1:0]    out_tdata;
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bit idle_on      = 1'b1;
  bit hold_request = 1'b0;
  int cycles       = 0;

  class envelope_tracker;
    logic [GAIN_W-1:0]             attack_gain;
    logic [GAIN_W-1:0]             release_gain;
    logic signed [FB_W-1:0]        attack_fb;
    logic signed [FB_W-1:0]        release_fb;
    logic signed [SAMPLE_BITS-1:0] left_env;
    logic signed [SAMPLE_BITS-1:0] right_env;
    logic [TDATA_W-1:0]            expected_env[$];
    int                            errors;

    function new();
      attack_gain  = '0;
      release_gain = '0;
      attack_fb    = '0;
      release_fb   = '0;
      left_env     = '0;
      right_env    = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
      case (addr)
        REG_ATTACK_GAIN:      attack_gain  = value[GAIN_W-1:0];
        REG_ATTACK_FEEDBACK:  attack_fb    = value[FB_W-1:0];
        REG_RELEASE_GAIN:     release_gain = value[GAIN_W-1:0];
        REG_RELEASE_FEEDBACK: release_fb   = value[FB_W-1:0];
        default: ;
      endcase
    endfunction

    function logic signed [SAMPLE_BITS-1:0] follow(logic signed [SAMPLE_BITS-1:0] x,
                                                   logic signed [SAMPLE_BITS-1:0] prev);
      longint g, f, acc, q, hi, lo;
      hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
      lo = -hi - 1;
      if (x > prev) begin
        g = longint'(attack_gain);
        f = longint'(attack_fb);
      end else begin
        g = longint'(release_gain);
        f = longint'(release_fb);
      end
      acc = g * longint'(x) + f * longint'(prev);
      // Division by the coefficient scale rounds toward zero on both signs.
      if (acc < 0) begin
        q = -((-acc) >>> COEF_FRAC_BITS);
      end else begin
        q = acc >>> COEF_FRAC_BITS;
      end
      if (q > hi) q = hi;
      if (q < lo) q = lo;
      return q[SAMPLE_BITS-1:0];
    endfunction

    function void note_pair(logic [TDATA_W-1:0] data);
      left_env  = follow(data[SAMPLE_BITS-1:0], left_env);
      right_env = follow(data[2*SAMPLE_BITS-1:SAMPLE_BITS], right_env);
      expected_env.push_back({right_env, left_env});
    endfunction

    function void check_env(logic [TDATA_W-1:0] data);
      logic [TDATA_W-1:0] want;
      if (expected_env.size() == 0) begin
        errors++;
        $display("%0t: output beat %h with no prediction waiting", $time, data);
        return;
      end
      want = expected_env.pop_front();
      if (data[SAMPLE_BITS-1:0] !== want[SAMPLE_BITS-1:0]) begin
        errors++;
        $display("%0t: left_env expected %0d, actual %0d", $time,
                 $signed(want[SAMPLE_BITS-1:0]), $signed(data[SAMPLE_BITS-1:0]));
      end
      if (data[2*SAMPLE_BITS-1:SAMPLE_BITS] !== want[2*SAMPLE_BITS-1:SAMPLE_BITS]) begin
        errors++;
        $display("%0t: right_env expected %0d, actual %0d", $time,
                 $signed(want[2*SAMPLE_BITS-1:SAMPLE_BITS]),
                 $signed(data[2*SAMPLE_BITS-1:SAMPLE_BITS]));
      end
    endfunction

    function int pending();
      return expected_env.size();
    endfunction
  endclass

  envelope_tracker sb = new();

  stereo_envelope_follower_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_env(out_tdata);
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = 80;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("** stereo_envelope_follower_top: FAILED **");
    $finish;
  end

  function automatic logic [TDATA_W-1:0] pair(logic [SAMPLE_BITS-1:0] l,
                                               logic [SAMPLE_BITS-1:0] r);
    return {r, l};
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(logic [SAMPLE_BITS-1:0] prev);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      1:       return prev;
      2:       return prev + SAMPLE_BITS'($urandom_range(0, 15)) - SAMPLE_BITS'(8);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic send_beat(input logic [TDATA_W-1:0] data);
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pair(data);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_coefs(input logic [CFG_DATA_W-1:0] ag, input logic [CFG_DATA_W-1:0] af,
                           input logic [CFG_DATA_W-1:0] rg, input logic [CFG_DATA_W-1:0] rf);
    logic [CFG_ADDR_W-1:0] addrs[4];
    logic [CFG_DATA_W-1:0] vals[4];
    addrs = '{REG_ATTACK_GAIN, REG_ATTACK_FEEDBACK, REG_RELEASE_GAIN, REG_RELEASE_FEEDBACK};
    vals  = '{ag, af, rg, rf};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr  <= addrs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.write_reg(addrs[i], vals[i]);
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_directed();
    send_beat(pair(16'h7FFF, 16'h8000));
    send_beat(pair(16'h8000, 16'h7FFF));
    send_beat(pair(16'h0000, 16'h0000));
    send_beat(pair(sb.left_env, sb.right_env));
    send_beat(pair(16'hFFFF, 16'h0001));
    send_beat(pair(16'h7FFF, 16'h7FFF));
    send_beat(pair(sb.left_env, sb.right_env));
    send_beat(pair(16'h8000, 16'h8000));
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_beat(pair(pick_sample(sb.left_env), pick_sample(sb.right_env)));
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_wr_en <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Coefficients straight out of reset give a silent envelope.
    send_random(20);
    drain();

    set_coefs(16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF);
    send_directed();
    send_random(130);
    drain();

    // Gain words with bit 15 set, which the gain registers drop, and feedbacks that drive saturation.
    set_coefs(16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000);
    send_directed();
    send_random(30);
    hold_request = 1'b1;
    send_random(100);
    drain();

    set_coefs(16'h0000, 16'h8000, 16'h0000, 16'hFFFF);
    send_directed();
    send_random(60);
    drain();
    send_random(70);
    drain();

    for (int p = 0; p < 4; p++) begin
      set_coefs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      send_random(150);
      drain();
    end

    idle_on = 1'b0;
    set_coefs(16'h0001, 16'hFFFF, 16'h7FFF, 16'h0001);
    send_random(160);
    drain();
    repeat (10) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** stereo_envelope_follower_top: PASSED **");
    end else begin
      $display("** stereo_envelope_follower_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sef_pkg.sv
rtl/core/sef_lane.sv
rtl/core/sef_ctrl.sv
rtl/core/stereo_envelope_follower_top.sv
bench/tb_top.sv
